/* design/lfg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lagged Fibonacci generator package
// Shared widths, lags, operation codes, default seed table and chain control.
// ----------------------------------------------------------------------------
package lfg_pkg;

  localparam int WORD_W    = 32;
  localparam int POS_W     = 6;
  localparam int RING_LEN  = 55;
  localparam int PHASE_MIN = 55;
  localparam int PHASE_MAX = 109;
  localparam int LONG_TAP  = 31;

  typedef enum logic {
    OP_GEN  = 1'b0,
    OP_LOAD = 1'b1
  } opcode_t;

  localparam logic [WORD_W-1:0] SEED_TABLE [RING_LEN] = '{
    32'd1607813071, 32'd410442638,  32'd1521159381, 32'd471588148,  32'd1656306875,
    32'd1877698854, 32'd1457017985, 32'd1885636224, 32'd2120983145, 32'd838865274,
    32'd622391523,  32'd1599495796, 32'd1589420163, 32'd646358994,  32'd1902836023,
    32'd294190104,  32'd528352961,  32'd810165570,  32'd2008068603, 32'd2064065124,
    32'd148481515,  32'd1874022922, 32'd444511217,  32'd1229535568, 32'd1447190841,
    32'd97924086,   32'd1532317171, 32'd1092420292, 32'd112366451,  32'd1855143102,
    32'd1983737863, 32'd650553016,  32'd612584047,  32'd899301394,  32'd863131509,
    32'd204748396,  32'd1301536603, 32'd1906202310, 32'd284925217,  32'd1675295776,
    32'd619597367,  32'd965140710,  32'd413816387,  32'd831647212,  32'd960766755,
    32'd2021366322, 32'd1709289321, 32'd745170552,  32'd719637471,  32'd174912226,
    32'd524134565,  32'd1957015236, 32'd1065289589, 32'd490210922,  32'd644050577
  };

  typedef struct packed {
    logic              shift;
    logic              gen;
    logic              load_en;
    logic [POS_W-1:0]  load_pos;
    logic [WORD_W-1:0] load_val;
  } chain_ctrl_t;

endpackage
`default_nettype wire

/* design/lfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lagged Fibonacci generator channels
// Request and result channels with valid/ready transfer handshake.
// ----------------------------------------------------------------------------
interface lfg_in_if;
  logic                     valid;
  logic                     ready;
  logic [0:0]               opcode;
  logic [lfg_pkg::POS_W-1:0] index;
  logic [31:0]              value;

  modport source (output valid, output opcode, output index, output value, input ready);
  modport sink   (input valid, input opcode, input index, input value, output ready);
endinterface

interface lfg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface
`default_nettype wire

/* design/lfg_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lagged Fibonacci generator cell
// One word of the lag chain: takes its neighbour's word on shift, or a seed.
// ----------------------------------------------------------------------------
module lfg_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [lfg_pkg::WORD_W-1:0] seed,
  input  wire logic                       load_hit,
  input  wire logic [lfg_pkg::WORD_W-1:0] load_val,
  input  wire logic                       shift_en,
  input  wire logic [lfg_pkg::WORD_W-1:0] shift_in,
  output logic      [lfg_pkg::WORD_W-1:0] word
);

  logic [lfg_pkg::WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= seed;
    end else if (load_hit) begin
      word_r <= load_val;
    end else if (shift_en) begin
      word_r <= shift_in;
    end
  end

  assign word = word_r;

endmodule
`default_nettype wire

/* design/lfg_chain.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lagged Fibonacci generator chain
// Row of cells holding the ring oldest-first; head and lag tap feed the adder.
// ----------------------------------------------------------------------------
module lfg_chain (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire lfg_pkg::chain_ctrl_t       ctrl,
  output logic      [lfg_pkg::WORD_W-1:0] sum
);

  logic [lfg_pkg::WORD_W-1:0] word [lfg_pkg::RING_LEN];
  logic [lfg_pkg::WORD_W-1:0] tail_in;

  assign sum     = word[0] + word[lfg_pkg::LONG_TAP];
  assign tail_in = ctrl.gen ? sum : word[0];

  for (genvar k = 0; k < lfg_pkg::RING_LEN; k++) begin : g_cell
    logic [lfg_pkg::WORD_W-1:0] next_word;
    logic                       hit;

    if (k == lfg_pkg::RING_LEN - 1) begin : g_tail
      assign next_word = tail_in;
    end else begin : g_body
      assign next_word = word[k+1];
    end

    assign hit = ctrl.load_en && (ctrl.load_pos == lfg_pkg::POS_W'(k));

    lfg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .seed     (lfg_pkg::SEED_TABLE[k]),
      .load_hit (hit),
      .load_val (ctrl.load_val),
      .shift_en (ctrl.shift),
      .shift_in (next_word),
      .word     (word[k])
    );
  end

endmodule
`default_nettype wire

/* design/lagged_fibonacci_generator_core.sv */
// A generate transfer shows its word on the result channel in the next cycle.
// Throughput: one generate or seed load per cycle while the input channel is ready.
// Phase load: the chain rotates one cell a cycle to the new phase,
// with the input channel not ready meanwhile.
// Reset: the chain takes the default seed table and the phase returns to 55.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Additive lagged Fibonacci generator, lags 24 and 55
// Control, phase tracking and registered result stage around the cell chain.
// ----------------------------------------------------------------------------
module lagged_fibonacci_generator_core (
  input wire logic clk,
  input wire logic rst_n,
  lfg_in_if.sink   in_ch,
  lfg_out_if.source out_ch
);

  logic [lfg_pkg::POS_W-1:0]  p_r, p_nxt;
  logic [lfg_pkg::POS_W-1:0]  target_r, target_nxt;
  logic                       rot_r, rot_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [31:0]                out_word_r;
  logic                       accept, is_gen, is_load;
  logic [lfg_pkg::POS_W-1:0]  p_inc, ld_sel, ld_pos, new_p;
  logic                       seed_ld, phase_ld, in_range;
  logic [lfg_pkg::WORD_W-1:0] sum;
  lfg_pkg::chain_ctrl_t       ctrl;

  assign in_ch.ready = !rot_r && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_gen      = accept && (in_ch.opcode == lfg_pkg::OP_GEN);
  assign is_load     = accept && (in_ch.opcode == lfg_pkg::OP_LOAD);

  assign p_inc  = (p_r == lfg_pkg::POS_W'(lfg_pkg::RING_LEN - 1)) ? '0 : p_r + 1'b1;
  assign ld_sel = in_ch.index - 1'b1;
  assign ld_pos = (ld_sel >= p_r) ? ld_sel - p_r
                                  : ld_sel + lfg_pkg::POS_W'(lfg_pkg::RING_LEN) - p_r;

  assign seed_ld  = is_load && (in_ch.index != '0)
                 && (in_ch.index <= lfg_pkg::POS_W'(lfg_pkg::RING_LEN));
  assign phase_ld = is_load && (in_ch.index == '0);
  assign in_range = (in_ch.value >= 32'(lfg_pkg::PHASE_MIN))
                 && (in_ch.value <= 32'(lfg_pkg::PHASE_MAX));
  assign new_p    = in_range ? lfg_pkg::POS_W'(in_ch.value - 32'(lfg_pkg::PHASE_MIN)) : '0;

  always_comb begin
    ctrl.shift    = is_gen || rot_r;
    ctrl.gen      = is_gen;
    ctrl.load_en  = seed_ld;
    ctrl.load_pos = ld_pos;
    ctrl.load_val = lfg_pkg::WORD_W'(in_ch.value);
  end

  lfg_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .sum   (sum)
  );

  always_comb begin
    p_nxt      = p_r;
    target_nxt = target_r;
    rot_nxt    = rot_r;
    if (rot_r) begin
      p_nxt   = p_inc;
      rot_nxt = (p_inc != target_r);
    end else if (is_gen) begin
      p_nxt = p_inc;
    end else if (phase_ld) begin
      target_nxt = new_p;
      rot_nxt    = (new_p != p_r);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (is_gen) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r         <= '0;
      target_r    <= '0;
      rot_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_r         <= p_nxt;
      target_r    <= target_nxt;
      rot_r       <= rot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_gen) begin
      out_word_r <= 32'(sum);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.random_word = out_word_r;

endmodule
`default_nettype wire

/* design/lfg_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lagged Fibonacci generator port checker
// Watches the channel ports for results following generate transfers and hold behaviour.
// ----------------------------------------------------------------------------
module lfg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [0:0]  in_opcode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_random_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_random_word))
    else $error("result word changed while stalled");

  a_gen_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == lfg_pkg::OP_GEN) |=> out_valid)
    else $error("generate transfer gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_opcode == lfg_pkg::OP_GEN)))
    else $error("result without a generate transfer");

endmodule

bind lagged_fibonacci_generator_core lfg_checker u_lfg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_opcode       (in_ch.opcode),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_random_word (out_ch.random_word)
);
`default_nettype wire

/* dv/tb_lagged_fibonacci_generator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lagged Fibonacci generator core testbench
// Drives generate and load transfers through the request channel, tracks the
// lag ring and phase alongside the block, and compares every result word
// against the tracked sum under varying source and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_lagged_fibonacci_generator_core;

  localparam int SHORT_LAG   = lfg_pkg::RING_LEN - lfg_pkg::LONG_TAP;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 480;
  localparam int TAIL_CYCLES = 60;

  class lag_ring_tracker;
    logic [lfg_pkg::WORD_W-1:0] ring [lfg_pkg::RING_LEN];
    int unsigned                phase;
    logic [lfg_pkg::WORD_W-1:0] pending_words [$];
    int                         errors;
    int                         n_gen, n_seed, n_phase, n_ignored, n_checked;

    function new();
      for (int i = 0; i < lfg_pkg::RING_LEN; i++) ring[i] = lfg_pkg::SEED_TABLE[i];
      phase = lfg_pkg::PHASE_MIN;
      errors = 0;
      n_gen = 0; n_seed = 0; n_phase = 0; n_ignored = 0; n_checked = 0;
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    function void note_transfer(lfg_pkg::opcode_t op, logic [lfg_pkg::POS_W-1:0] idx,
                                logic [lfg_pkg::WORD_W-1:0] val);
      int unsigned                slot, partner;
      logic [lfg_pkg::WORD_W-1:0] sum;
      if (op == lfg_pkg::OP_LOAD) begin
        if (idx == 0) begin
          if (val >= lfg_pkg::PHASE_MIN && val <= lfg_pkg::PHASE_MAX) phase = val;
          else phase = lfg_pkg::PHASE_MIN;
          n_phase++;
        end else if (idx <= lfg_pkg::RING_LEN) begin
          ring[idx - 1] = val;
          n_seed++;
        end else begin
          n_ignored++;
        end
      end else begin
        slot    = phase - lfg_pkg::PHASE_MIN;
        partner = (slot < SHORT_LAG) ? slot + lfg_pkg::LONG_TAP : slot - SHORT_LAG;
        sum     = ring[partner] + ring[slot];
        ring[slot] = sum;
        phase   = (phase >= lfg_pkg::PHASE_MAX) ? lfg_pkg::PHASE_MIN : phase + 1;
        pending_words.push_back(sum);
        n_gen++;
      end
    endfunction

    function void check_word(logic [lfg_pkg::WORD_W-1:0] got);
      logic [lfg_pkg::WORD_W-1:0] want;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_words.pop_front();
        n_checked++;
        if (got !== want) begin
          $display("%0t: random_word mismatch, expected %h, actual %h", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lfg_in_if  in_ch ();
  lfg_out_if out_ch ();

  lagged_fibonacci_generator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lag_ring_tracker tracker;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int cycles         = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("RESULT: ERROR");
    $finish;
  end

  // sink side: check transfers, then pick next ready
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) tracker.check_word(out_ch.random_word);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [lfg_pkg::WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic send_item(lfg_pkg::opcode_t op, int unsigned idx,
                           logic [lfg_pkg::WORD_W-1:0] val);
    int gap;
    logic [lfg_pkg::POS_W-1:0] idx_bits;
    gap = 0;
    idx_bits = lfg_pkg::POS_W'(idx);
    while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.index  <= idx_bits;
    in_ch.value  <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_transfer(op, idx_bits, val);
  endtask

  task automatic pause_sender();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic send_generate();
    send_item(lfg_pkg::OP_GEN, $urandom_range(0, 63), $urandom);
  endtask

  // full reseed of the ring, new phase, then a run of words
  task automatic reseed_run(inout int count);
    int n;
    for (int i = 1; i <= lfg_pkg::RING_LEN; i++) send_item(lfg_pkg::OP_LOAD, i, pick_word());
    send_item(lfg_pkg::OP_LOAD, 0, $urandom_range(lfg_pkg::PHASE_MIN, lfg_pkg::PHASE_MAX));
    n = $urandom_range(20, 80);
    repeat (n) send_generate();
    count += lfg_pkg::RING_LEN + 1 + n;
  endtask

  task automatic random_item(inout int count);
    int r;
    logic [lfg_pkg::WORD_W-1:0] v;
    r = $urandom_range(0, 999);
    if (r < 6) begin
      reseed_run(count);
    end else if (r < 806) begin
      send_generate();
      count++;
    end else if (r < 886) begin
      send_item(lfg_pkg::OP_LOAD, $urandom_range(1, lfg_pkg::RING_LEN), pick_word());
      count++;
    end else if (r < 946) begin
      case ($urandom_range(0, 7))
        0: v = $urandom;
        1: v = $urandom_range(0, lfg_pkg::PHASE_MIN - 1);
        2: v = $urandom_range(lfg_pkg::PHASE_MAX + 1, 127);
        default: v = $urandom_range(lfg_pkg::PHASE_MIN, lfg_pkg::PHASE_MAX);
      endcase
      send_item(lfg_pkg::OP_LOAD, 0, v);
      count++;
    end else begin
      send_item(lfg_pkg::OP_LOAD, $urandom_range(lfg_pkg::RING_LEN + 1, 63), $urandom);
      count++;
    end
  endtask

  task automatic directed_items();
    send_item(lfg_pkg::OP_GEN, 0, '0);
    send_item(lfg_pkg::OP_GEN, '1, '1);
    send_item(lfg_pkg::OP_GEN, lfg_pkg::RING_LEN, 32'h8000_0001);
    send_item(lfg_pkg::OP_LOAD, 0, lfg_pkg::PHASE_MAX);
    send_item(lfg_pkg::OP_GEN, 0, 0);
    send_item(lfg_pkg::OP_GEN, 0, 0);
    send_item(lfg_pkg::OP_LOAD, 0, lfg_pkg::PHASE_MIN + SHORT_LAG - 1);
    send_item(lfg_pkg::OP_GEN, 0, 0);
    send_item(lfg_pkg::OP_GEN, 0, 0);
    send_item(lfg_pkg::OP_LOAD, 1, '1);
    send_item(lfg_pkg::OP_LOAD, lfg_pkg::RING_LEN, '1);
    send_item(lfg_pkg::OP_LOAD, lfg_pkg::LONG_TAP + 1, '1);
    send_item(lfg_pkg::OP_LOAD, 0, lfg_pkg::PHASE_MIN);
    send_item(lfg_pkg::OP_GEN, 0, 0);
    send_item(lfg_pkg::OP_LOAD, lfg_pkg::RING_LEN + 1, '1);
    send_item(lfg_pkg::OP_LOAD, 63, '1);
    send_item(lfg_pkg::OP_LOAD, 0, lfg_pkg::PHASE_MIN - 1);
    send_item(lfg_pkg::OP_GEN, 0, 0);
    send_item(lfg_pkg::OP_LOAD, 0, lfg_pkg::PHASE_MAX + 1);
    send_item(lfg_pkg::OP_GEN, 0, 0);
    send_item(lfg_pkg::OP_LOAD, 0, '1);
    send_item(lfg_pkg::OP_GEN, 0, 0);
    send_item(lfg_pkg::OP_LOAD, 0, '0);
    send_item(lfg_pkg::OP_GEN, 0, 0);
    send_item(lfg_pkg::OP_LOAD, 0, lfg_pkg::PHASE_MAX);
  endtask

  initial begin
    int  sent;
    bit  held;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.opcode <= lfg_pkg::OP_GEN;
    in_ch.index  <= '0;
    in_ch.value  <= '0;
    tracker = new();
    held = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    directed_items();
    pause_sender();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (mode == 0 && !held && sent >= 200) begin
          // sink holds off while words keep coming, to back up the block
          held = 1'b1;
          hold_req = 1'b1;
          repeat (60) send_generate();
          sent += 60;
          pause_sender();
        end
        random_item(sent);
      end
      pause_sender();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d generates, %0d seed loads, %0d phase loads, %0d ignored loads",
             tracker.n_gen, tracker.n_seed, tracker.n_phase, tracker.n_ignored);
    $display("checked %0d words over four back-pressure phases and one long sink hold-off",
             tracker.n_checked);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* lagged_fibonacci_generator_core.f */
design/lfg_pkg.sv
design/lfg_if.sv
design/lfg_cell.sv
design/lfg_chain.sv
design/lagged_fibonacci_generator_core.sv
design/lfg_checker.sv
dv/tb_lagged_fibonacci_generator_core.sv
